[hw/rtl/crwo_pkg.sv]
// types and codes shared by the column run and window overlap block
`timescale 1ns / 1ps

package crwo_pkg;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_WINDOW = 1'b1;

  localparam logic KIND_RUN    = 1'b0;
  localparam logic KIND_WINDOW = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [5:0]  column_index;
    logic [5:0]  start_row;
    logic [63:0] column_bits;
  } crwo_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [5:0]  out_column;
    logic [5:0]  out_row;
    logic [6:0]  out_length;
    logic [6:0]  overlap_count;
    logic [12:0] total_set_pixels;
    logic        none_found;
    logic        last;
  } crwo_result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_TOTAL,
    ST_SCAN,
    ST_EMPTY
  } crwo_state_t;

endpackage

[hw/rtl/column_run_and_window_overlap.sv]
// top level: column store, run extraction and window overlap enumeration
`timescale 1ns / 1ps

// Holds a WIDTH x WIDTH binary image as WIDTH column words in a memory that
// reads back empty after reset (per-entry valid bits, no clearing pass).
// One item is worked on at a time; while the output register is free it
// scans one row per cycle and emits at most one record. A load item reads
// the old column word, counts old and new pixels and updates the total, then
// scans from row 0 to the row that closes the last run (the bottom row for
// an empty column). A window item reads its word and scans from start_row to
// the bottom. An item with a column or start row outside the image puts out
// one empty record. A new item is taken once the previous one has put out
// its last record; the record itself may still sit in the output register.

module column_run_and_window_overlap
  import crwo_pkg::*;
#(
  parameter int WIDTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  crwo_item_t   req,
  input  logic         req_valid,
  output logic         req_ready,
  output crwo_result_t rsp,
  output logic         rsp_valid,
  input  logic         rsp_ready
);

  localparam int RW = $clog2(WIDTH);
  localparam logic [RW-1:0] LAST_ROW = RW'(WIDTH - 1);

  // two-level adder tree over eight bytes
  function automatic logic [6:0] popcount64(input logic [63:0] v);
    logic [3:0] part [8];
    logic [6:0] sum;
    for (int i = 0; i < 8; i++) begin
      part[i] = '0;
      for (int j = 0; j < 8; j++) begin
        part[i] = part[i] + 4'(v[8*i+j]);
      end
    end
    sum = '0;
    for (int i = 0; i < 8; i++) begin
      sum = sum + 7'(part[i]);
    end
    return sum;
  endfunction

  crwo_state_t state, state_next;

  logic              mode_q;
  logic [5:0]        col_q;
  logic [RW-1:0]     start_q;
  logic [WIDTH-1:0]  new_word;
  logic [WIDTH-1:0]  word;
  logic [RW-1:0]     row;
  logic [RW-1:0]     run_start;
  logic              in_run;
  logic [6:0]        cnt;
  logic [6:0]        pop_old;
  logic [6:0]        pop_new;
  logic [12:0]       total;

  logic              rd_en;
  logic [WIDTH-1:0]  rd_data;
  logic              wr_en;

  logic              accept;
  logic              bad_item;
  logic              slot_free;
  logic              load_out;
  logic              step;
  crwo_result_t      out_rec;

  logic              bit_now;
  logic              last_row;
  logic [RW:0]       row_ext;
  logic [WIDTH-1:0]  rows_below;
  logic              rest_any;
  logic [6:0]        cnt_next;
  logic [RW-1:0]     cur_start;
  logic              emit;
  logic              rec_last;
  logic [RW-1:0]     rec_row;
  logic [6:0]        rec_len;
  logic [6:0]        rec_ovl;
  logic              scan_done;

  crwo_colmem #(
    .WIDTH(WIDTH)
  ) u_colmem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (req.column_index[RW-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (col_q[RW-1:0]),
    .wr_data (new_word)
  );

  assign slot_free = !rsp_valid || rsp_ready;
  assign bad_item  = (7'(req.column_index) >= 7'(WIDTH)) ||
                     ((req.mode == MODE_WINDOW) && (7'(req.start_row) >= 7'(WIDTH)));

  // scan of one row
  always_comb begin
    bit_now    = word[row];
    last_row   = (row == LAST_ROW);
    row_ext    = {1'b0, row};
    rows_below = {WIDTH{1'b1}} << (row_ext + 1'b1);
    rest_any   = |(word & rows_below);
    cnt_next   = cnt + 7'(bit_now);
    cur_start  = in_run ? run_start : row;
    if (mode_q == MODE_LOAD) begin
      // a run closes on a clear pixel or at the bottom row
      emit     = (in_run && !bit_now) || (bit_now && last_row);
      rec_row  = cur_start;
      rec_len  = bit_now ? (7'(row) + 7'd1 - 7'(cur_start)) : (7'(row) - 7'(cur_start));
      rec_ovl  = '0;
      rec_last = bit_now || !rest_any;
    end else begin
      // counts only grow, so every window after the first hit is emitted
      emit     = (cnt_next != '0);
      rec_row  = start_q;
      rec_len  = 7'(row) - 7'(start_q) + 7'd1;
      rec_ovl  = cnt_next;
      rec_last = last_row;
    end
    scan_done = last_row || (emit && rec_last);
  end

  always_comb begin
    out_rec.result_kind      = mode_q;
    out_rec.out_column       = col_q;
    out_rec.out_row          = '0;
    out_rec.out_length       = '0;
    out_rec.overlap_count    = '0;
    out_rec.total_set_pixels = total;
    out_rec.none_found       = 1'b1;
    out_rec.last             = 1'b1;
    if (state == ST_SCAN && emit) begin
      out_rec.out_row       = 6'(rec_row);
      out_rec.out_length    = rec_len;
      out_rec.overlap_count = rec_ovl;
      out_rec.none_found    = 1'b0;
      out_rec.last          = rec_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    accept     = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    load_out   = 1'b0;
    step       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          accept = 1'b1;
          if (bad_item) begin
            state_next = ST_EMPTY;
          end else begin
            rd_en      = 1'b1;
            state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        if (mode_q == MODE_LOAD) begin
          wr_en      = 1'b1;
          state_next = ST_TOTAL;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_TOTAL: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (slot_free) begin
          step     = 1'b1;
          load_out = emit || last_row;
          if (scan_done) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_EMPTY: begin
        if (slot_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (state == ST_TOTAL) begin
      total <= total - 13'(pop_old) + 13'(pop_new);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q   <= req.mode;
      col_q    <= req.column_index;
      start_q  <= req.start_row[RW-1:0];
      new_word <= req.column_bits[WIDTH-1:0];
    end
    if (state == ST_READ) begin
      word    <= (mode_q == MODE_LOAD) ? new_word : rd_data;
      pop_old <= popcount64(64'(rd_data));
      pop_new <= popcount64(64'(new_word));
      row     <= (mode_q == MODE_LOAD) ? '0 : start_q;
      in_run  <= 1'b0;
      cnt     <= '0;
    end else if (step) begin
      row    <= row + 1'b1;
      in_run <= bit_now;
      cnt    <= cnt_next;
      if (bit_now && !in_run) begin
        run_start <= row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp <= out_rec;
    end
  end

endmodule

[hw/rtl/crwo_colmem.sv]
// column word memory with per-entry valid bits and a registered read
`timescale 1ns / 1ps

module crwo_colmem #(
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [$clog2(WIDTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(WIDTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [WIDTH];
  logic [WIDTH-1:0] valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // an entry never written reads as an empty column
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= valid[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule

[sim/tb.sv]
// testbench for the column run and window overlap block
`timescale 1ns / 1ps

import crwo_pkg::*;

class record_scoreboard;
  localparam int ROWS = 64;

  logic [63:0] image_columns [ROWS];
  logic [12:0] pixel_total;
  crwo_result_t expected_records [$];
  int unsigned errors;

  function new();
    foreach (image_columns[i]) image_columns[i] = '0;
    pixel_total = '0;
    errors = 0;
  endfunction

  function int unsigned pixel_count(logic [63:0] w);
    int unsigned n;
    n = 0;
    for (int i = 0; i < 64; i++) n += w[i];
    return n;
  endfunction

  function crwo_result_t make_record(logic kind, logic [5:0] col, int unsigned row,
                                     int unsigned len, int unsigned ovl, logic none);
    crwo_result_t rec;
    rec = '0;
    rec.result_kind = kind;
    rec.out_column = col;
    rec.out_row = 6'(row);
    rec.out_length = 7'(len);
    rec.overlap_count = 7'(ovl);
    rec.total_set_pixels = pixel_total;
    rec.none_found = none;
    return rec;
  endfunction

  // works out the records one accepted item causes and queues them
  function void note_item(crwo_item_t it);
    crwo_result_t batch [$];
    crwo_result_t rec;
    logic [63:0] word;
    int unsigned row, first, cnt;
    if (it.column_index < ROWS) begin
      if (it.mode == MODE_LOAD) begin
        word = it.column_bits;
        pixel_total = pixel_total - 13'(pixel_count(image_columns[it.column_index]))
                      + 13'(pixel_count(word));
        image_columns[it.column_index] = word;
        row = 0;
        while (row < ROWS) begin
          if (word[row]) begin
            first = row;
            while (row < ROWS && word[row]) row++;
            batch = {batch, make_record(KIND_RUN, it.column_index, first, row - first,
                                        0, 1'b0)};
          end else begin
            row++;
          end
        end
      end else if (it.start_row < ROWS) begin
        word = image_columns[it.column_index] >> it.start_row;
        cnt = 0;
        // each longer window adds one row, so the overlap grows by at most one
        for (int len = 1; len <= ROWS - it.start_row; len++) begin
          cnt += word[len-1];
          if (cnt != 0)
            batch = {batch, make_record(KIND_WINDOW, it.column_index, it.start_row,
                                        len, cnt, 1'b0)};
        end
      end
    end
    if (batch.size() == 0)
      batch = {batch, make_record(it.mode, it.column_index, 0, 0, 0, 1'b1)};
    foreach (batch[i]) begin
      rec = batch[i];
      rec.last = (i == batch.size() - 1);
      expected_records = {expected_records, rec};
    end
  endfunction

  function void compare(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  function void check_record(crwo_result_t got);
    crwo_result_t want;
    if (expected_records.size() == 0) begin
      $error("record with nothing expected: %h", got);
      errors++;
      return;
    end
    want = expected_records.pop_front();
    compare("result_kind", want.result_kind, got.result_kind);
    compare("out_column", want.out_column, got.out_column);
    compare("out_row", want.out_row, got.out_row);
    compare("out_length", want.out_length, got.out_length);
    compare("overlap_count", want.overlap_count, got.overlap_count);
    compare("total_set_pixels", want.total_set_pixels, got.total_set_pixels);
    compare("none_found", want.none_found, got.none_found);
    compare("last", want.last, got.last);
  endfunction

  function int unsigned pending();
    return expected_records.size();
  endfunction
endclass

module tb;
  localparam int IMG_W = 64;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  crwo_item_t   req = '0;
  logic         req_valid = 1'b0;
  logic         req_ready;
  crwo_result_t rsp;
  logic         rsp_valid;
  logic         rsp_ready = 1'b0;

  record_scoreboard board = new();

  int unsigned burst_left = 4;
  int unsigned records_seen = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned pattern_left = 0;
  logic [31:0] stall_pattern = '1;
  logic [5:0]  last_loaded = '0;

  column_run_and_window_overlap #(.WIDTH(IMG_W)) u_top (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .rsp      (rsp),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic crwo_item_t make_item(logic mode, int unsigned col, int unsigned row,
                                           logic [63:0] bits);
    crwo_item_t it;
    it.mode = mode;
    it.column_index = 6'(col);
    it.start_row = 6'(row);
    it.column_bits = bits;
    return it;
  endfunction

  function automatic logic [63:0] random_bits();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] random_column();
    logic [63:0] w;
    int unsigned a, b;
    case ($urandom_range(0, 6))
      0: w = random_bits();
      1: w = random_bits() & random_bits() & random_bits();
      2: w = random_bits() | random_bits() | random_bits();
      3: begin
        a = $urandom_range(0, 63);
        b = $urandom_range(a, 63);
        w = (ALL_ONES << a) & (ALL_ONES >> (63 - b));
      end
      4: w = (ALL_ONES << $urandom_range(0, 63)) ^ (ALL_ONES << $urandom_range(0, 63));
      5: w = $urandom_range(0, 1) ? ALL_ONES : '0;
      default: w = 64'd1 << $urandom_range(0, 63);
    endcase
    return w;
  endfunction

  // offer one item, hold it until taken, then maybe idle
  task automatic offer_item(crwo_item_t it);
    int unsigned gap;
    req <= it;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    board.note_item(it);
    if (it.mode == MODE_LOAD) last_loaded = it.column_index;
    if (burst_left > 1) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 15);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 8);
    end
  endtask

  task automatic random_item();
    int unsigned col, row;
    col = $urandom_range(0, 1) ? last_loaded : $urandom_range(0, IMG_W - 1);
    if ($urandom_range(0, 99) < 45) begin
      offer_item(make_item(MODE_LOAD, col, $urandom_range(0, 63), random_column()));
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: row = $urandom_range(0, 7);
        4, 5, 6:    row = $urandom_range(0, 63);
        default:    row = $urandom_range(56, 63);
      endcase
      offer_item(make_item(MODE_WINDOW, col, row, random_bits()));
    end
  endtask

  // receiver: checks records and stalls on a changing rotating pattern
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        board.check_record(rsp);
        records_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && records_seen >= 300) begin
        // long hold-off so the block backs up into its input
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (pattern_left == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pattern = '1;
          1: stall_pattern = $urandom;
          2: stall_pattern = $urandom | $urandom;
          default: stall_pattern = $urandom & $urandom;
        endcase
        pattern_left = $urandom_range(20, 150);
      end else begin
        pattern_left--;
      end
      stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
      rsp_ready <= (hold_left == 0) && stall_pattern[0];
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // window on an empty store, then extremes of column words
    offer_item(make_item(MODE_WINDOW, 5, 0, ALL_ONES));
    offer_item(make_item(MODE_LOAD, 0, 63, '0));
    offer_item(make_item(MODE_LOAD, 0, 0, ALL_ONES));
    offer_item(make_item(MODE_WINDOW, 0, 0, '0));
    offer_item(make_item(MODE_WINDOW, 0, 63, ALL_ONES));
    offer_item(make_item(MODE_LOAD, 63, 17, 64'h5555_5555_5555_5555));
    offer_item(make_item(MODE_LOAD, 62, 42, 64'hAAAA_AAAA_AAAA_AAAA));
    offer_item(make_item(MODE_WINDOW, 63, 1, random_bits()));
    offer_item(make_item(MODE_WINDOW, 62, 0, random_bits()));
    // single pixel in the bottom row
    offer_item(make_item(MODE_LOAD, 1, 5, 64'h8000_0000_0000_0000));
    offer_item(make_item(MODE_WINDOW, 1, 0, '0));
    offer_item(make_item(MODE_WINDOW, 1, 63, '0));
    offer_item(make_item(MODE_WINDOW, 1, 62, '0));
    // rewrites take the old pixels off the total
    offer_item(make_item(MODE_LOAD, 0, 0, 64'd1));
    offer_item(make_item(MODE_LOAD, 0, 0, '0));
    offer_item(make_item(MODE_WINDOW, 0, 10, ALL_ONES));
    offer_item(make_item(MODE_LOAD, 2, 63, 64'd1));
    offer_item(make_item(MODE_WINDOW, 2, 1, '0));
    offer_item(make_item(MODE_WINDOW, 2, 0, '0));
    offer_item(make_item(MODE_LOAD, 63, 0, ALL_ONES));

    for (int i = 0; i < 250; i++) begin
      // fill the whole image once to reach the largest total
      if (i == 100)
        for (int c = 0; c < IMG_W; c++) offer_item(make_item(MODE_LOAD, c, c, ALL_ONES));
      random_item();
    end
    req_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
